@@ hw/rtl/cxalu_pkg.sv @@
// Package with shared types and codes for the complex accumulator ALU.
`timescale 1ns / 1ps
package cxalu_pkg;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_LOAD = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  localparam int unsigned OperandBits = 32;
  localparam int unsigned StatusBits  = 2;

endpackage

@@ hw/rtl/cxalu_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`timescale 1ns / 1ps
module cxalu_mul
  import cxalu_pkg::*;
#(
  parameter int unsigned W = 32,
  parameter int unsigned P = 2 * W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [P-1:0] p_o
);
  localparam int unsigned CntBits = $clog2(W + 1);

  logic [P-1:0]       acc_q, acc_d;
  logic [P-1:0]       mcand_q, mcand_d;
  logic [W-1:0]       mplier_q, mplier_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;

  // Signed multiply with two's complement multiplier: the top bit weighs -2^(W-1).
  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = P'(a_i);
      mplier_d = b_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        if (cnt_q == CntBits'(W - 1)) acc_d = acc_q - mcand_q;
        else                          acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CntBits'(W - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  // The product is complete in the cycle done is high, including the last step.
  assign done_o = busy_q && !busy_d && !start_i;
  assign p_o    = acc_d;
endmodule

@@ hw/rtl/cxalu_div.sv @@
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module cxalu_div
  import cxalu_pkg::*;
#(
  parameter int unsigned N = 80,
  parameter int unsigned D = 65
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] num_i,
  input  logic [D-1:0] den_i,
  output logic         done_o,
  output logic [N-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(N + 1);

  logic [N-1:0]       q_q, q_d;
  logic [D:0]         r_q, r_d;
  logic [D-1:0]       den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [D:0]         trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {r_q[D-1:0], q_q[N-1]};
    if (start_i) begin
      q_d    = num_i;
      r_d    = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q};
        q_d = {q_q[N-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(N - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  // The quotient is complete in the cycle done is high, including the last bit.
  assign done_o = busy_q && !busy_d && !start_i;
  assign quo_o  = q_d;
endmodule

@@ hw/rtl/complex_accumulator_alu.sv @@
// Top level of the complex accumulator ALU with bit-serial multiply and divide.
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake            Contents
//  s_axis   in   tvalid/tready        operands, operation in tuser
//  m_axis   out  tvalid/tready        result parts, status in tuser
//
// Add, subtract, load and unused codes pass from acceptance through S_FIN and
// S_OUT to the result word. Multiply runs four products in a row through the
// shift-add multiplier. Divide runs six products, then, unless the denominator
// is zero, two quotients of 2*max(WORD_BITS,32)+FRAC_BITS+3 bits through one
// radix-2 divider. One word is in flight at a time. Reset clears the
// accumulator and control. A stalled m_axis holds the result; s_axis_tready
// stays low until it is taken.
module complex_accumulator_alu
  import cxalu_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operand_re [31:0], operand_im [63:32]
  input  logic [63:0] s_axis_tdata,
  // tuser: mode [2:0], operand_is_real [3], store_result [4]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: result_re [31:0], result_im [63:32]
  output logic [63:0] m_axis_tdata,
  // tuser: status [1:0]
  output logic [1:0]  m_axis_tuser
);
  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned MW = ((W > 32) ? W : 32) + 1; // factor width covers both operands
  localparam int unsigned PW = 2 * MW;         // product width
  localparam int unsigned SW = PW + 1;         // sum of two products
  localparam int unsigned NW = SW + FRAC_BITS; // shifted numerator
  localparam int unsigned XW = NW + 2;         // wide working value

  state_e            state_q, state_d;
  logic [2:0]        mode_q;
  logic              store_q;
  logic signed [MW-1:0] c_q, d_q;
  logic signed [W-1:0]  acc_re_q, acc_im_q;
  logic [1:0]        step_q;
  logic signed [SW-1:0] s_re_q, s_im_q;   // product sums
  logic signed [SW-1:0] den_q;
  logic              div_im_q;
  logic signed [XW-1:0] rr_q, ri_q;
  logic [W-1:0]      out_re_q, out_im_q;
  logic [1:0]        status_q;
  logic              mvalid_q;

  logic              mul_start, mul_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic              div_start, div_done;
  logic [NW-1:0]     div_num, div_quo;
  logic [SW-2:0]     div_den;
  logic              num_neg;
  logic signed [SW-1:0] num_sel;
  logic signed [MW-1:0] a_ext, b_ext;

  assign a_ext = MW'(acc_re_q);
  assign b_ext = MW'(acc_im_q);

  // Multiply mode: ac, bd, ad, bc. Divide mode: ac, bd, ad, bc, then cc, dd.
  logic [2:0] mstep_q;
  always_comb begin
    mul_a = a_ext;
    mul_b = c_q;
    unique case (mstep_q)
      3'd0: begin mul_a = a_ext; mul_b = c_q; end
      3'd1: begin mul_a = b_ext; mul_b = d_q; end
      3'd2: begin mul_a = a_ext; mul_b = d_q; end
      3'd3: begin mul_a = b_ext; mul_b = c_q; end
      3'd4: begin mul_a = c_q;   mul_b = c_q; end
      3'd5: begin mul_a = d_q;   mul_b = d_q; end
      default: ;
    endcase
  end

  cxalu_mul #(.W(MW), .P(PW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  assign num_sel = div_im_q ? s_im_q : s_re_q;
  assign num_neg = num_sel[SW-1] ^ den_q[SW-1];
  assign div_num = {(num_sel[SW-1] ? SW'(-num_sel) : SW'(num_sel)),
                    {FRAC_BITS{1'b0}}};
  assign div_den = den_q[SW-2:0];

  cxalu_div #(.N(NW), .D(SW - 1)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Saturation to the signed word range.
  function automatic logic [W:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi, lo;
    hi = (XW'(1) << (W - 1)) - XW'(1);
    lo = -hi - XW'(1);
    if (v > hi)      sat = {1'b1, hi[W-1:0]};
    else if (v < lo) sat = {1'b1, lo[W-1:0]};
    else             sat = {1'b0, v[W-1:0]};
  endfunction

  logic [W:0] sr, si;
  assign sr = sat(rr_q);
  assign si = sat(ri_q);

  logic accept;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !mvalid_q;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept) begin
        if (s_axis_tuser[2:0] == MODE_MUL || s_axis_tuser[2:0] == MODE_DIV)
          state_d = S_MUL;
        else
          state_d = S_FIN;
      end
      S_MUL: begin
        if (step_q == 2'd0) mul_start = 1'b1;
        if (mul_done) begin
          if ((mode_q == MODE_MUL && mstep_q == 3'd3) ||
              (mode_q == MODE_DIV && mstep_q == 3'd5)) begin
            if (mode_q == MODE_MUL) state_d = S_FIN;
            else                    state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (step_q == 2'd0 && den_q != '0) div_start = 1'b1;
        if (den_q == '0) state_d = S_FIN;
        else if (div_done && div_im_q) state_d = S_FIN;
      end
      S_FIN: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      acc_re_q <= '0;
      acc_im_q <= '0;
      mvalid_q <= 1'b0;
      step_q   <= '0;
      mstep_q  <= '0;
      div_im_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mvalid_q && m_axis_tready) mvalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          step_q   <= '0;
          mstep_q  <= '0;
          div_im_q <= 1'b0;
          if (accept) begin
            mode_q  <= s_axis_tuser[2:0];
            store_q <= s_axis_tuser[4];
            c_q     <= MW'($signed(s_axis_tdata[31:0]));
            d_q     <= s_axis_tuser[3] ? '0 : MW'($signed(s_axis_tdata[63:32]));
          end
        end
        S_MUL: begin
          step_q <= 2'd1;
          if (mul_done) begin
            step_q  <= '0;
            mstep_q <= mstep_q + 3'd1;
            unique case (mstep_q)
              3'd0: s_re_q <= SW'(mul_p);
              3'd1: s_re_q <= (mode_q == MODE_MUL) ? s_re_q - SW'(mul_p)
                                                   : s_re_q + SW'(mul_p);
              3'd2: s_im_q <= SW'(mul_p);
              3'd3: s_im_q <= (mode_q == MODE_MUL) ? s_im_q + SW'(mul_p)
                                                   : SW'(mul_p) - s_im_q;
              3'd4: den_q  <= SW'(mul_p);
              3'd5: den_q  <= den_q + SW'(mul_p);
              default: ;
            endcase
          end
        end
        S_DIV: begin
          step_q <= 2'd1;
          if (div_done) begin
            step_q <= '0;
            if (div_im_q) ri_q <= num_neg ? -XW'(div_quo) : XW'(div_quo);
            else          rr_q <= num_neg ? -XW'(div_quo) : XW'(div_quo);
            div_im_q <= 1'b1;
          end
        end
        S_FIN: begin
          unique case (mode_q)
            MODE_ADD: begin
              rr_q <= XW'(acc_re_q) + XW'(c_q);
              ri_q <= XW'(acc_im_q) + XW'(d_q);
            end
            MODE_SUB: begin
              rr_q <= XW'(acc_re_q) - XW'(c_q);
              ri_q <= XW'(acc_im_q) - XW'(d_q);
            end
            MODE_MUL: begin
              rr_q <= XW'(s_re_q >>> FRAC_BITS);
              ri_q <= XW'(s_im_q >>> FRAC_BITS);
            end
            MODE_DIV: ;
            MODE_LOAD: begin
              rr_q <= XW'(c_q);
              ri_q <= XW'(d_q);
            end
            default: begin
              rr_q <= XW'(acc_re_q);
              ri_q <= XW'(acc_im_q);
            end
          endcase
        end
        S_OUT: begin
          mvalid_q <= 1'b1;
          if (mode_q == MODE_DIV && den_q == '0) begin
            out_re_q <= '0;
            out_im_q <= '0;
            status_q <= ST_DIVZERO;
          end else begin
            out_re_q <= sr[W-1:0];
            out_im_q <= si[W-1:0];
            status_q <= (sr[W] || si[W]) ? ST_SAT : ST_OK;
            if (mode_q == MODE_LOAD ||
                (store_q && (mode_q == MODE_ADD || mode_q == MODE_SUB ||
                             mode_q == MODE_MUL || mode_q == MODE_DIV))) begin
              acc_re_q <= sr[W-1:0];
              acc_im_q <= si[W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {32'(out_im_q), 32'(out_re_q)};
  assign m_axis_tuser  = status_q;

  // The input side stays closed while a result word waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  // A division by zero never reports saturation values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_DIVZERO) |-> (m_axis_tdata == '0))
    else $error("divide by zero result not cleared");

  // Status codes stay in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("bad status code");

  // Multiplier and divider are never started together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("arithmetic units started together");
endmodule
